### sv/tgcc_pkg.sv
// tgcc_pkg: shared types, constants and register codes for the tile grid
// circle collision block
// no dependencies
package tgcc_pkg;

  // grid geometry
  localparam int GRID_CELLS = 4096;
  localparam int GRID_AW    = $clog2(GRID_CELLS);

  // field widths
  localparam int CELL_IDX_W = 12;
  localparam int TILE_W     = 8;
  localparam int POS_W      = 16;
  localparam int OFS_W      = 13;
  localparam int RAD_W      = 12;
  localparam int TS_W       = 3;
  localparam int MW_W       = 13;

  // centre and edge coordinates, 1/16 pixel units
  localparam int COORD_W    = 18;
  // cell column or row, signed
  localparam int CELL_W     = 14;
  localparam int PROD_W     = 2 * MW_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int SH_W       = 4;
  localparam logic [SH_W-1:0] BASE_SHIFT = 4'd4;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;
  localparam logic [CFG_AW-1:0] REG_TILE_SHIFT   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ROW_TILES    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_COLLISION_EN = 2'd2;

  localparam logic [TS_W-1:0] TILE_SHIFT_RST = 3'd4;
  localparam logic [MW_W-1:0] ROW_TILES_RST  = 13'd64;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic [TILE_W-1:0] TILE_SOLID = 8'd1;

  // direction codes
  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;

  // queues
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_AW    = 2;
  localparam int RESQ_CW    = 3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_SKIP  = 2'd2
  } op_t;

  // neighbour lookup order of a query
  typedef enum logic [1:0] {
    NB_LEFT   = 2'd0,
    NB_RIGHT  = 2'd1,
    NB_TOP    = 2'd2,
    NB_BOTTOM = 2'd3
  } nb_t;

  typedef struct packed {
    logic [TS_W-1:0] tile_shift;
    logic [MW_W-1:0] row_tiles;
    logic            collision_enabled;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic [CELL_IDX_W-1:0]   cell_index;
    logic                    solid;
    logic signed [CELL_W-1:0] ccol;
    logic signed [CELL_W-1:0] crow;
    logic signed [CELL_W-1:0] left;
    logic signed [CELL_W-1:0] right;
    logic signed [CELL_W-1:0] top;
    logic signed [CELL_W-1:0] bottom;
  } work_t;

  typedef struct packed {
    logic              collided;
    logic signed [1:0] dir_x;
    logic signed [1:0] dir_y;
  } res_t;

endpackage

### sv/tgcc_front.sv
// tgcc_front: accepts items, forms the circle centre and edge cells, and
// hands classified work to the command queue
// depends on tgcc_pkg
module tgcc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tgcc_pkg::cfg_t                       cfg,
  input  logic                                 clearing,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_command,
  input  logic [tgcc_pkg::CELL_IDX_W-1:0]      in_cell_index,
  input  logic [tgcc_pkg::TILE_W-1:0]          in_tile_value,
  input  logic [tgcc_pkg::POS_W-1:0]           in_pos_x,
  input  logic [tgcc_pkg::POS_W-1:0]           in_pos_y,
  input  logic signed [tgcc_pkg::OFS_W-1:0]    in_offset_x,
  input  logic signed [tgcc_pkg::OFS_W-1:0]    in_offset_y,
  input  logic [tgcc_pkg::RAD_W-1:0]           in_radius,
  output logic                                 wk_valid,
  input  logic                                 wk_ready,
  output tgcc_pkg::work_t                      wk
);

  // stage 1: centre
  logic                                   s1_v_r;
  tgcc_pkg::op_t                          s1_op_r;
  logic [tgcc_pkg::CELL_IDX_W-1:0]        s1_cell_r;
  logic                                   s1_solid_r;
  logic signed [tgcc_pkg::COORD_W-1:0]    s1_cx_r;
  logic signed [tgcc_pkg::COORD_W-1:0]    s1_cy_r;
  logic [tgcc_pkg::RAD_W-1:0]             s1_rad_r;

  // stage 2: classified work
  logic                                   s2_v_r;
  tgcc_pkg::work_t                        s2_wk_r;
  tgcc_pkg::work_t                        s2_wk_nxt;

  logic                                   s1_en;
  logic                                   s2_en;
  logic                                   accept;
  tgcc_pkg::op_t                          op_in;
  logic signed [tgcc_pkg::COORD_W-1:0]    cx_in;
  logic signed [tgcc_pkg::COORD_W-1:0]    cy_in;
  logic signed [tgcc_pkg::COORD_W-1:0]    rad_s;
  logic [tgcc_pkg::SH_W-1:0]              sh;

  assign s2_en   = !s2_v_r || wk_ready;
  assign s1_en   = !s1_v_r || s2_en;
  assign in_full = clearing || !s1_en;
  assign accept  = in_push && !in_full;

  always_comb begin
    if (in_command == tgcc_pkg::CMD_WRITE) begin
      op_in = tgcc_pkg::OP_WRITE;
    end else if (cfg.collision_enabled) begin
      op_in = tgcc_pkg::OP_QUERY;
    end else begin
      op_in = tgcc_pkg::OP_SKIP;
    end
  end

  assign cx_in = $signed({2'b00, in_pos_x}) + tgcc_pkg::COORD_W'(in_offset_x);
  assign cy_in = $signed({2'b00, in_pos_y}) + tgcc_pkg::COORD_W'(in_offset_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && accept) begin
      s1_op_r    <= op_in;
      s1_cell_r  <= in_cell_index;
      s1_solid_r <= (in_tile_value == tgcc_pkg::TILE_SOLID);
      s1_cx_r    <= cx_in;
      s1_cy_r    <= cy_in;
      s1_rad_r   <= in_radius;
    end
  end

  // floor division by the tile edge is an arithmetic shift
  assign sh    = tgcc_pkg::BASE_SHIFT + tgcc_pkg::SH_W'(cfg.tile_shift);
  assign rad_s = $signed({{(tgcc_pkg::COORD_W - tgcc_pkg::RAD_W){1'b0}}, s1_rad_r});

  always_comb begin
    s2_wk_nxt.op         = s1_op_r;
    s2_wk_nxt.cell_index = s1_cell_r;
    s2_wk_nxt.solid      = s1_solid_r;
    s2_wk_nxt.ccol       = tgcc_pkg::CELL_W'(s1_cx_r >>> sh);
    s2_wk_nxt.crow       = tgcc_pkg::CELL_W'(s1_cy_r >>> sh);
    s2_wk_nxt.left       = tgcc_pkg::CELL_W'((s1_cx_r - rad_s) >>> sh);
    s2_wk_nxt.right      = tgcc_pkg::CELL_W'((s1_cx_r + rad_s) >>> sh);
    s2_wk_nxt.top        = tgcc_pkg::CELL_W'((s1_cy_r - rad_s) >>> sh);
    s2_wk_nxt.bottom     = tgcc_pkg::CELL_W'((s1_cy_r + rad_s) >>> sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      s2_wk_r <= s2_wk_nxt;
    end
  end

  assign wk_valid = s2_v_r;
  assign wk       = s2_wk_r;

endmodule

### sv/tgcc_cmdq.sv
// tgcc_cmdq: short queue of classified work between front and back
// depends on tgcc_pkg
module tgcc_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tgcc_pkg::work_t wk_in,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tgcc_pkg::work_t wk_out
);

  tgcc_pkg::work_t                 mem_r [tgcc_pkg::CMDQ_DEPTH];
  logic [tgcc_pkg::CMDQ_AW-1:0]    wptr_r;
  logic [tgcc_pkg::CMDQ_AW-1:0]    rptr_r;
  logic [tgcc_pkg::CMDQ_CW-1:0]    cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (cnt_r == tgcc_pkg::CMDQ_CW'(tgcc_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign wk_out  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wk_in;
    end
  end

endmodule

### sv/tgcc_resq.sv
// tgcc_resq: result queue on the output side, reports its fill level to
// the back end for credit
// depends on tgcc_pkg
module tgcc_resq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  tgcc_pkg::res_t                res_in,
  input  logic                          pop,
  output logic                          empty,
  output tgcc_pkg::res_t                res_out,
  output logic [tgcc_pkg::RESQ_CW-1:0]  cnt
);

  tgcc_pkg::res_t                  mem_r [tgcc_pkg::RESQ_DEPTH];
  logic [tgcc_pkg::RESQ_AW-1:0]    wptr_r;
  logic [tgcc_pkg::RESQ_AW-1:0]    rptr_r;
  logic [tgcc_pkg::RESQ_CW-1:0]    cnt_r;
  logic                            do_pop;

  // the back end never pushes into a full queue, its credit check sees to that
  assign empty   = (cnt_r == '0);
  assign do_pop  = pop && !empty;
  assign res_out = mem_r[rptr_r];
  assign cnt     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= res_in;
    end
  end

endmodule

### sv/tgcc_back.sv
// tgcc_back: grid memory with clearing pass and the neighbour lookup pipeline
// (issue, address, read/accumulate)
// depends on tgcc_pkg
module tgcc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tgcc_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  tgcc_pkg::work_t               q_wk,
  output logic                          q_pop,
  input  logic [tgcc_pkg::RESQ_CW-1:0]  resq_cnt,
  output logic                          res_push,
  output tgcc_pkg::res_t                res,
  output logic                          clearing
);

  // grid memory and clearing pass
  logic                           grid_mem [tgcc_pkg::GRID_CELLS];
  logic                           clr_busy_r;
  logic [tgcc_pkg::GRID_AW-1:0]   clr_addr_r;

  // stage a: issue
  tgcc_pkg::nb_t                  step_r;
  tgcc_pkg::nb_t                  step_nxt;
  logic                           a_go;
  logic                           a_last;
  logic                           a_inb;
  logic                           credit_ok;
  logic [tgcc_pkg::RESQ_CW-1:0]   inflight;
  logic signed [tgcc_pkg::CELL_W-1:0] a_col;
  logic signed [tgcc_pkg::CELL_W-1:0] a_row;

  // stage b: address
  logic                           b_v_r;
  logic                           b_last_r;
  logic                           b_look_r;
  logic                           b_wr_r;
  logic                           b_solid_r;
  logic [tgcc_pkg::CELL_IDX_W-1:0] b_cell_r;
  logic [tgcc_pkg::PROD_W-1:0]    b_prod_r;
  logic [tgcc_pkg::MW_W-1:0]      b_col_r;
  tgcc_pkg::nb_t                  b_kind_r;
  logic [tgcc_pkg::SUM_W-1:0]     b_sum;
  logic                           b_rd_en;
  logic                           b_wr_en;

  // stage c: read data and accumulate
  logic                           c_v_r;
  logic                           c_last_r;
  logic                           c_look_r;
  tgcc_pkg::nb_t                  c_kind_r;
  logic                           rd_r;
  logic                           c_hit;
  tgcc_pkg::res_t                 acc_r;
  tgcc_pkg::res_t                 acc_nxt;

  assign clearing = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == tgcc_pkg::GRID_AW'(tgcc_pkg::GRID_CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // results already on their way hold a queue slot each
  assign inflight  = tgcc_pkg::RESQ_CW'(b_v_r && b_last_r) +
                     tgcc_pkg::RESQ_CW'(c_v_r && c_last_r);
  assign credit_ok = (resq_cnt + inflight) < tgcc_pkg::RESQ_CW'(tgcc_pkg::RESQ_DEPTH);
  assign a_go      = !q_empty && !clr_busy_r && credit_ok;
  assign a_last    = (q_wk.op != tgcc_pkg::OP_QUERY) || (step_r == tgcc_pkg::NB_BOTTOM);
  assign q_pop     = a_go && a_last;

  always_comb begin
    unique case (step_r)
      tgcc_pkg::NB_LEFT: begin
        a_col = q_wk.left;   a_row = q_wk.crow;   step_nxt = tgcc_pkg::NB_RIGHT;
      end
      tgcc_pkg::NB_RIGHT: begin
        a_col = q_wk.right;  a_row = q_wk.crow;   step_nxt = tgcc_pkg::NB_TOP;
      end
      tgcc_pkg::NB_TOP: begin
        a_col = q_wk.ccol;   a_row = q_wk.top;    step_nxt = tgcc_pkg::NB_BOTTOM;
      end
      tgcc_pkg::NB_BOTTOM: begin
        a_col = q_wk.ccol;   a_row = q_wk.bottom; step_nxt = tgcc_pkg::NB_LEFT;
      end
      default: begin
        a_col = q_wk.left;   a_row = q_wk.crow;   step_nxt = tgcc_pkg::NB_LEFT;
      end
    endcase
  end

  // a non-negative cell fits in the low bits
  assign a_inb = !a_col[tgcc_pkg::CELL_W-1] && !a_row[tgcc_pkg::CELL_W-1] &&
                 (a_col[tgcc_pkg::MW_W-1:0] < cfg.row_tiles);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tgcc_pkg::NB_LEFT;
    end else if (a_go) begin
      step_r <= a_last ? tgcc_pkg::NB_LEFT : step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r    <= 1'b0;
      b_last_r <= 1'b0;
    end else begin
      b_v_r    <= a_go;
      b_last_r <= a_go && a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_look_r  <= (q_wk.op == tgcc_pkg::OP_QUERY) && a_inb;
      b_wr_r    <= (q_wk.op == tgcc_pkg::OP_WRITE);
      b_solid_r <= q_wk.solid;
      b_cell_r  <= q_wk.cell_index;
      b_prod_r  <= a_row[tgcc_pkg::MW_W-1:0] * cfg.row_tiles;
      b_col_r   <= a_col[tgcc_pkg::MW_W-1:0];
      b_kind_r  <= step_r;
    end
  end

  // linear index, cells past the grid end read as free
  assign b_sum   = {1'b0, b_prod_r} + tgcc_pkg::SUM_W'(b_col_r);
  assign b_rd_en = b_v_r && b_look_r &&
                   (32'(b_sum) < 32'(tgcc_pkg::GRID_CELLS));
  assign b_wr_en = b_v_r && b_wr_r &&
                   (32'(b_cell_r) < 32'(tgcc_pkg::GRID_CELLS));

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      grid_mem[clr_addr_r] <= 1'b0;
    end else if (b_wr_en) begin
      grid_mem[tgcc_pkg::GRID_AW'(b_cell_r)] <= b_solid_r;
    end
    if (b_rd_en) begin
      rd_r <= grid_mem[tgcc_pkg::GRID_AW'(b_sum)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r    <= 1'b0;
      c_last_r <= 1'b0;
      c_look_r <= 1'b0;
    end else begin
      c_v_r    <= b_v_r;
      c_last_r <= b_v_r && b_last_r;
      c_look_r <= b_rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (b_v_r) begin
      c_kind_r <= b_kind_r;
    end
  end

  // each neighbour cell is found from a circle edge, so its closest point
  // is always within the radius: a solid neighbour is a hit
  assign c_hit = c_v_r && c_look_r && rd_r;

  always_comb begin
    acc_nxt = acc_r;
    if (c_hit) begin
      acc_nxt.collided = 1'b1;
      unique case (c_kind_r)
        tgcc_pkg::NB_LEFT:   acc_nxt.dir_x = tgcc_pkg::DIR_NEG;
        tgcc_pkg::NB_RIGHT:  acc_nxt.dir_x = tgcc_pkg::DIR_POS;
        tgcc_pkg::NB_TOP:    acc_nxt.dir_y = tgcc_pkg::DIR_NEG;
        tgcc_pkg::NB_BOTTOM: acc_nxt.dir_y = tgcc_pkg::DIR_POS;
        default:             acc_nxt = acc_r;
      endcase
    end
  end

  assign res_push = c_v_r && c_last_r;
  assign res      = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (res_push) begin
      acc_r <= '0;
    end else if (c_v_r) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

### sv/tile_grid_circle_collision_top.sv
// tile_grid_circle_collision_top: top level of the tile grid circle collision
// block; depends on tgcc_pkg, tgcc_front, tgcc_cmdq, tgcc_back, tgcc_resq
//
// A grid of solid-tile bits answers circle-versus-tile queries. After reset the
// grid is cleared by a pass over all 4096 cells (one cell a cycle) during which
// in_full stays high; configuration writes are taken at any time. A write item
// (command 0) stores one cell and returns an all-zero result; a query item
// (command 1) returns collided and the hit sides, or all zero with collision
// disabled. Every item gives exactly one result, in order. The front end takes
// one item a cycle, while in_full is low, into a two-stage pipeline; the back
// end reads the grid through its single memory port, one cell lookup per cycle
// while work is queued and the result queue has credit, so a query looks up its
// left, right, top and bottom cells in turn and a write item or a query with
// collision disabled needs no lookup. A four-entry result queue lets results
// wait for out_pop while new items keep coming in.
module tile_grid_circle_collision_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [tgcc_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [tgcc_pkg::CFG_DW-1:0]        cfg_wdata,
  // item input side
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_command,
  input  logic [tgcc_pkg::CELL_IDX_W-1:0]    in_cell_index,
  input  logic [tgcc_pkg::TILE_W-1:0]        in_tile_value,
  input  logic [tgcc_pkg::POS_W-1:0]         in_pos_x,
  input  logic [tgcc_pkg::POS_W-1:0]         in_pos_y,
  input  logic signed [tgcc_pkg::OFS_W-1:0]  in_offset_x,
  input  logic signed [tgcc_pkg::OFS_W-1:0]  in_offset_y,
  input  logic [tgcc_pkg::RAD_W-1:0]         in_radius,
  // result side
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_collided,
  output logic signed [1:0]                  out_dir_x,
  output logic signed [1:0]                  out_dir_y
);

  tgcc_pkg::cfg_t                  cfg_r;
  logic                            clearing;
  logic                            wk_valid;
  logic                            cmdq_full;
  tgcc_pkg::work_t                 wk;
  logic                            q_empty;
  logic                            q_pop;
  tgcc_pkg::work_t                 q_wk;
  logic                            res_push;
  tgcc_pkg::res_t                  res;
  tgcc_pkg::res_t                  res_head;
  logic [tgcc_pkg::RESQ_CW-1:0]    resq_cnt;

  // configuration registers, an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_shift        <= tgcc_pkg::TILE_SHIFT_RST;
      cfg_r.row_tiles         <= tgcc_pkg::ROW_TILES_RST;
      cfg_r.collision_enabled <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tgcc_pkg::REG_TILE_SHIFT:
          cfg_r.tile_shift <= cfg_wdata[tgcc_pkg::TS_W-1:0];
        tgcc_pkg::REG_ROW_TILES:
          cfg_r.row_tiles <= cfg_wdata[tgcc_pkg::MW_W-1:0];
        tgcc_pkg::REG_COLLISION_EN:
          cfg_r.collision_enabled <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // front: centre, edge cells and item kind
  tgcc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .clearing      (clearing),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_cell_index (in_cell_index),
    .in_tile_value (in_tile_value),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_offset_x   (in_offset_x),
    .in_offset_y   (in_offset_y),
    .in_radius     (in_radius),
    .wk_valid      (wk_valid),
    .wk_ready      (!cmdq_full),
    .wk            (wk)
  );

  // decouples front and back
  tgcc_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (wk_valid),
    .wk_in  (wk),
    .full   (cmdq_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .wk_out (q_wk)
  );

  // back: grid memory and neighbour lookups
  tgcc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_wk     (q_wk),
    .q_pop    (q_pop),
    .resq_cnt (resq_cnt),
    .res_push (res_push),
    .res      (res),
    .clearing (clearing)
  );

  // results wait here for the consumer
  tgcc_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .res_in  (res),
    .pop     (out_pop),
    .empty   (out_empty),
    .res_out (res_head),
    .cnt     (resq_cnt)
  );

  assign out_collided = res_head.collided;
  assign out_dir_x    = res_head.dir_x;
  assign out_dir_y    = res_head.dir_y;

endmodule
